@@ rtl/plc_intcode_executor_macros.svh @@
// assertion macros for the intcode executor
`ifndef PLC_INTCODE_EXECUTOR_MACROS_SVH
`define PLC_INTCODE_EXECUTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define PIE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PIE_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define PIE_ASSERT(label, clk, rst_n, prop)
`define PIE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/pie_pkg.sv @@
// shared types and codes of the intcode executor
package pie_pkg;

  localparam logic [2:0] REQ_INSTR  = 3'd0;
  localparam logic [2:0] REQ_SCAN   = 3'd1;
  localparam logic [2:0] REQ_TOGGLE = 3'd2;
  localparam logic [2:0] REQ_ADC    = 3'd3;
  localparam logic [2:0] REQ_RXIN   = 3'd4;
  localparam logic [2:0] REQ_RDVAR  = 3'd5;
  localparam logic [2:0] REQ_RDBIT  = 3'd6;
  localparam logic [2:0] REQ_RSVD   = 3'd7;

  localparam logic [4:0] OP_NODE   = 5'd0;
  localparam logic [4:0] OP_SET    = 5'd1;
  localparam logic [4:0] OP_CLR    = 5'd2;
  localparam logic [4:0] OP_COPY   = 5'd3;
  localparam logic [4:0] OP_MOVL   = 5'd4;
  localparam logic [4:0] OP_MOVV   = 5'd5;
  localparam logic [4:0] OP_INC    = 5'd6;
  localparam logic [4:0] OP_ADD    = 5'd7;
  localparam logic [4:0] OP_SUB    = 5'd8;
  localparam logic [4:0] OP_MUL    = 5'd9;
  localparam logic [4:0] OP_DIV    = 5'd10;
  localparam logic [4:0] OP_IFSET  = 5'd11;
  localparam logic [4:0] OP_IFCLR  = 5'd12;
  localparam logic [4:0] OP_IFLT   = 5'd13;
  localparam logic [4:0] OP_IFEQ   = 5'd14;
  localparam logic [4:0] OP_IFGT   = 5'd15;
  localparam logic [4:0] OP_PWM    = 5'd16;
  localparam logic [4:0] OP_EEBUSY = 5'd17;
  localparam logic [4:0] OP_EERD   = 5'd18;
  localparam logic [4:0] OP_EEWR   = 5'd19;
  localparam logic [4:0] OP_RDADC  = 5'd20;
  localparam logic [4:0] OP_TX     = 5'd21;
  localparam logic [4:0] OP_RX     = 5'd22;
  localparam logic [4:0] OP_ENDIF  = 5'd23;
  localparam logic [4:0] OP_ELSE   = 5'd24;
  localparam logic [4:0] OP_CMT    = 5'd25;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_SKIP    = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  localparam logic [1:0] TX_BUSY_SCANS = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MULDV = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  // multiply/divide unit control
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

@@ rtl/pie_muldiv.sv @@
// iterative 16-bit signed multiplier and divider, one bit per cycle
module pie_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pie_pkg::md_ctrl_t   ctrl_i,
  input  logic signed [15:0]  op_a_i,
  input  logic signed [15:0]  op_b_i,
  output pie_pkg::md_stat_t   stat_o,
  output logic [15:0]         result_o
);
  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        div_q, div_d, neg_q, neg_d;
  logic [15:0] acc_q, acc_d;   // product or remainder
  logic [15:0] sh_q, sh_d;     // multiplier or dividend/quotient
  logic [15:0] mc_q, mc_d;     // multiplicand or divisor magnitude
  logic [16:0] trial;
  logic [15:0] mag_a, mag_b;

  assign mag_a = op_a_i[15] ? 16'(-op_a_i) : op_a_i;
  assign mag_b = op_b_i[15] ? 16'(-op_b_i) : op_b_i;
  assign trial = {acc_q, sh_q[15]} - {1'b0, mc_q};

  // sequencer
  always_comb begin
    busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q; div_d = div_q;
    neg_d = neg_q; acc_d = acc_q; sh_d = sh_q; mc_d = mc_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1; cnt_d = 5'd16; div_d = ctrl_i.is_div;
      neg_d = op_a_i[15] ^ op_b_i[15];
      acc_d = '0;
      sh_d = ctrl_i.is_div ? mag_a : op_b_i;
      mc_d = ctrl_i.is_div ? mag_b : op_a_i;
    end else if (busy_q) begin
      if (div_q) begin
        if (!trial[16]) begin
          acc_d = trial[15:0]; sh_d = {sh_q[14:0], 1'b1};
        end else begin
          acc_d = {acc_q[14:0], sh_q[15]}; sh_d = {sh_q[14:0], 1'b0};
        end
      end else begin
        // low 16 bits of the product: shift-add from the top bit
        acc_d = {acc_q[14:0], 1'b0} + (sh_q[15] ? mc_q : 16'd0);
        sh_d = {sh_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d; neg_q <= neg_d; acc_q <= acc_d; sh_q <= sh_d; mc_q <= mc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o = !div_q ? acc_q : (neg_q ? 16'(-sh_q) : sh_q);
endmodule

@@ rtl/plc_intcode_executor.sv @@
// top level of the ladder-logic intermediate code executor
// One transaction in, one result out. An instruction passes through memory
// read, execute, write back and output states from acceptance until its
// result can be taken, and the block is ready again in the cycle after the
// result is taken. A multiply, or a divide by a non-zero divisor, adds a pass
// through the shared one-bit-per-cycle unit (16 steps and a hand-over of the
// result). After reset a clearing pass over max(NUM_BITS, NUM_VARS) entries
// zeroes the tables before the first transaction is taken. The bit, variable
// and ADC tables are synchronous memories with registered reads; one
// transaction is worked at a time.
`include "plc_intcode_executor_macros.svh"
module plc_intcode_executor #(
  parameter int NUM_BITS    = 256,
  parameter int NUM_VARS    = 256,
  parameter int MAX_NESTING = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [4:0]         opcode_i,
  input  logic [7:0]         first_index_i,
  input  logic [7:0]         second_index_i,
  input  logic [7:0]         third_index_i,
  input  logic signed [15:0] literal_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [15:0] read_value_o,
  output logic               bit_value_o,
  output logic               tx_valid_o,
  output logic [7:0]         tx_byte_o
);
  localparam int BW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
  localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int NMAX = (NUM_BITS > NUM_VARS) ? NUM_BITS : NUM_VARS;
  localparam int CW = $clog2(NMAX) + 1;
  localparam int DW = $clog2(MAX_NESTING + 1);

  pie_pkg::state_e state_q, state_d;

  // memories
  logic        bit_mem [NUM_BITS];
  logic [15:0] var_mem [NUM_VARS];
  logic [15:0] adc_mem [NUM_VARS];

  // clearing pass
  logic          clr_q;
  logic [CW-1:0] clr_cnt_q;

  // captured transaction
  logic [2:0]  req_q;
  logic [4:0]  op_q;
  logic [7:0]  ia_q, ib_q, ic_q;
  logic [15:0] lit_q;

  // control state
  logic [DW-1:0] skip_q, skip_d;
  logic [1:0]    txc_q, txc_d;
  logic          rxp_q, rxp_d;
  logic [7:0]    rxb_q, rxb_d;
  logic          halt_q, halt_d;

  // read data
  logic        bra_q, brb_q;
  logic [15:0] vp0_q, vp1_q, adc_q;

  // variable read ports: b and c for MOVV and the two-operand ops, else a and b
  logic          vsel_bc;
  logic [VW-1:0] vp0_adr, vp1_adr;

  // write back
  logic          bw_en_q, bw_en_d, bw_val_q, bw_val_d;
  logic [BW-1:0] bw_adr_q, bw_adr_d;
  logic          vw_en_q, vw_en_d;
  logic [15:0]   vw_val_q, vw_val_d;
  logic [VW-1:0] vw_adr_q, vw_adr_d;

  // result register
  logic [2:0]  st_q, st_d;
  logic [15:0] rv_q, rv_d;
  logic        bv_q, bv_d, txv_q, txv_d;
  logic [7:0]  txb_q, txb_d;

  pie_pkg::md_ctrl_t md_ctrl;
  pie_pkg::md_stat_t md_stat;
  logic [15:0]       md_res;

  logic in_acc, out_acc;
  logic a_inb, b_inb, a_inv, b_inv, c_inv;
  logic signed [15:0] va, vb, vc, lit_s;
  logic ba, bb;

  assign in_stall_o  = (state_q != pie_pkg::S_IDLE) || clr_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == pie_pkg::S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign vsel_bc = (req_q == pie_pkg::REQ_INSTR) && (op_q inside {pie_pkg::OP_MOVV,
                   pie_pkg::OP_ADD, pie_pkg::OP_SUB, pie_pkg::OP_MUL, pie_pkg::OP_DIV});
  assign vp0_adr = vsel_bc ? VW'(ib_q) : VW'(ia_q);
  assign vp1_adr = vsel_bc ? VW'(ic_q) : VW'(ib_q);

  assign a_inb = 32'(ia_q) < NUM_BITS;
  assign b_inb = 32'(ib_q) < NUM_BITS;
  assign a_inv = 32'(ia_q) < NUM_VARS;
  assign b_inv = 32'(ib_q) < NUM_VARS;
  assign c_inv = 32'(ic_q) < NUM_VARS;
  assign ba = a_inb & bra_q;
  assign bb = b_inb & brb_q;
  assign va = a_inv ? vp0_q : 16'sd0;
  assign vb = !b_inv ? 16'sd0 : (vsel_bc ? vp0_q : vp1_q);
  assign vc = c_inv ? vp1_q : 16'sd0;
  assign lit_s = lit_q;

  // capture transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i; op_q <= opcode_i; ia_q <= first_index_i;
      ib_q <= second_index_i; ic_q <= third_index_i; lit_q <= literal_i;
    end
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    bra_q <= bit_mem[BW'(ia_q)];
    brb_q <= bit_mem[BW'(ib_q)];
    vp0_q <= var_mem[vp0_adr];
    vp1_q <= var_mem[vp1_adr];
    adc_q <= adc_mem[VW'(ia_q)];
  end

  // memory writes: clearing pass, write back, adc shadow
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      if (clr_cnt_q < CW'(NUM_BITS)) bit_mem[clr_cnt_q[BW-1:0]] <= 1'b0;
      if (clr_cnt_q < CW'(NUM_VARS)) begin
        var_mem[clr_cnt_q[VW-1:0]] <= '0;
        adc_mem[clr_cnt_q[VW-1:0]] <= '0;
      end
    end else if (state_q == pie_pkg::S_WRITE) begin
      if (bw_en_q) bit_mem[bw_adr_q] <= bw_val_q;
      if (vw_en_q) var_mem[vw_adr_q] <= vw_val_q;
      if (req_q == pie_pkg::REQ_ADC && a_inv) adc_mem[VW'(ia_q)] <= lit_q;
    end
  end

  assign md_ctrl.start  = (state_q == pie_pkg::S_EXEC) && !halt_q && req_q == pie_pkg::REQ_INSTR
                          && skip_q == '0 && (op_q == pie_pkg::OP_MUL
                          || (op_q == pie_pkg::OP_DIV && vc != 16'sd0));
  assign md_ctrl.is_div = (op_q == pie_pkg::OP_DIV);

  pie_muldiv u_md (
    .clk_i, .rst_ni, .ctrl_i(md_ctrl), .op_a_i(vb), .op_b_i(vc),
    .stat_o(md_stat), .result_o(md_res)
  );

  // execute
  always_comb begin
    state_d = state_q;
    skip_d = skip_q; txc_d = txc_q; rxp_d = rxp_q; rxb_d = rxb_q; halt_d = halt_q;
    bw_en_d = bw_en_q; bw_val_d = bw_val_q; bw_adr_d = bw_adr_q;
    vw_en_d = vw_en_q; vw_val_d = vw_val_q; vw_adr_d = vw_adr_q;
    st_d = st_q; rv_d = rv_q; bv_d = bv_q; txv_d = txv_q; txb_d = txb_q;
    case (state_q)
      pie_pkg::S_IDLE: if (in_acc) state_d = pie_pkg::S_READ;
      pie_pkg::S_READ: state_d = pie_pkg::S_EXEC;
      pie_pkg::S_EXEC: begin
        state_d = pie_pkg::S_WRITE;
        st_d = pie_pkg::ST_DONE; rv_d = '0; bv_d = 1'b0; txv_d = 1'b0; txb_d = '0;
        bw_en_d = 1'b0; bw_val_d = 1'b0; bw_adr_d = BW'(ia_q);
        vw_en_d = 1'b0; vw_val_d = '0; vw_adr_d = VW'(ia_q);
        case (req_q)
          pie_pkg::REQ_INSTR: begin
            if (halt_q) st_d = pie_pkg::ST_HALTED;
            else if (skip_q != '0) begin
              st_d = pie_pkg::ST_SKIP;
              if (op_q inside {[pie_pkg::OP_IFSET:pie_pkg::OP_IFGT]}) begin
                if (32'(skip_q) < MAX_NESTING) skip_d = skip_q + DW'(1);
              end else if (op_q == pie_pkg::OP_ENDIF) skip_d = skip_q - DW'(1);
              else if (op_q == pie_pkg::OP_ELSE && skip_q == DW'(1)) skip_d = '0;
            end else begin
              case (op_q)
                pie_pkg::OP_NODE: bv_d = ba;
                pie_pkg::OP_SET, pie_pkg::OP_EEBUSY: begin
                  bw_en_d = a_inb; bw_val_d = 1'b1;
                end
                pie_pkg::OP_CLR: bw_en_d = a_inb;
                pie_pkg::OP_COPY: begin bw_en_d = a_inb; bw_val_d = bb; end
                pie_pkg::OP_MOVL: begin vw_en_d = a_inv; vw_val_d = lit_q; end
                pie_pkg::OP_MOVV: begin vw_en_d = a_inv; vw_val_d = vb; end
                pie_pkg::OP_INC: begin vw_en_d = a_inv; vw_val_d = va + 16'sd1; end
                pie_pkg::OP_ADD: begin vw_en_d = a_inv; vw_val_d = vb + vc; end
                pie_pkg::OP_SUB: begin vw_en_d = a_inv; vw_val_d = vb - vc; end
                pie_pkg::OP_MUL: begin vw_en_d = a_inv; state_d = pie_pkg::S_MULDV; end
                pie_pkg::OP_DIV: begin
                  vw_en_d = a_inv;
                  if (vc == 16'sd0) begin
                    halt_d = 1'b1; st_d = pie_pkg::ST_DIVZERO;
                  end else state_d = pie_pkg::S_MULDV;
                end
                pie_pkg::OP_IFSET: if (!ba) skip_d = DW'(1);
                pie_pkg::OP_IFCLR: if (ba) skip_d = DW'(1);
                pie_pkg::OP_IFLT: if (!(va < lit_s)) skip_d = DW'(1);
                pie_pkg::OP_IFEQ: if (va != vb) skip_d = DW'(1);
                pie_pkg::OP_IFGT: if (!(va > vb)) skip_d = DW'(1);
                pie_pkg::OP_PWM, pie_pkg::OP_ENDIF, pie_pkg::OP_CMT: ;
                pie_pkg::OP_RDADC: begin vw_en_d = a_inv; vw_val_d = adc_q; end
                pie_pkg::OP_TX: begin
                  bw_adr_d = BW'(ib_q); bw_en_d = b_inb;
                  if (bb && txc_q == 2'd0) begin
                    txc_d = pie_pkg::TX_BUSY_SCANS; txv_d = 1'b1; txb_d = va[7:0];
                    bw_val_d = 1'b1;
                  end else bw_val_d = (txc_q != 2'd0);
                end
                pie_pkg::OP_RX: begin
                  bw_adr_d = BW'(ib_q); bw_en_d = b_inb; bw_val_d = rxp_q;
                  if (rxp_q) begin
                    vw_en_d = a_inv; vw_val_d = {8'd0, rxb_q}; rxp_d = 1'b0;
                  end
                end
                pie_pkg::OP_ELSE: skip_d = DW'(1);
                default: st_d = pie_pkg::ST_ILLEGAL;
              endcase
            end
          end
          pie_pkg::REQ_SCAN: begin
            if (halt_q) st_d = pie_pkg::ST_HALTED;
            else begin
              if (txc_q != 2'd0) txc_d = txc_q - 2'd1;
              skip_d = '0;
            end
          end
          pie_pkg::REQ_TOGGLE: begin bw_en_d = a_inb; bw_val_d = !ba; end
          pie_pkg::REQ_ADC: ;
          pie_pkg::REQ_RXIN: begin rxp_d = 1'b1; rxb_d = lit_q[7:0]; end
          pie_pkg::REQ_RDVAR: rv_d = va;
          pie_pkg::REQ_RDBIT: bv_d = ba;
          default: st_d = pie_pkg::ST_ILLEGAL;
        endcase
      end
      pie_pkg::S_MULDV: if (md_stat.done) begin
        vw_val_d = md_res; state_d = pie_pkg::S_WRITE;
      end
      pie_pkg::S_WRITE: state_d = pie_pkg::S_OUT;
      pie_pkg::S_OUT: if (out_acc) state_d = pie_pkg::S_IDLE;
      default: state_d = pie_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pie_pkg::S_IDLE; clr_q <= 1'b1; clr_cnt_q <= '0;
      skip_q <= '0; txc_q <= '0; rxp_q <= 1'b0; rxb_q <= '0; halt_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + CW'(1);
        if (clr_cnt_q == CW'(NMAX - 1)) clr_q <= 1'b0;
      end
      skip_q <= skip_d; txc_q <= txc_d; rxp_q <= rxp_d; rxb_q <= rxb_d; halt_q <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bw_en_q <= bw_en_d; bw_val_q <= bw_val_d; bw_adr_q <= bw_adr_d;
    vw_en_q <= vw_en_d; vw_val_q <= vw_val_d; vw_adr_q <= vw_adr_d;
    st_q <= st_d; rv_q <= rv_d; bv_q <= bv_d; txv_q <= txv_d; txb_q <= txb_d;
  end

  assign status_o = st_q;
  assign read_value_o = rv_q;
  assign bit_value_o = bv_q;
  assign tx_valid_o = txv_q;
  assign tx_byte_o = txb_q;

  // checks
  `PIE_ASSERT_NEVER(a_halt_falls, clk_i, rst_ni, $fell(halt_q))
  `PIE_ASSERT(a_md_only_in_muldv, clk_i, rst_ni,
              md_stat.busy |-> state_q == pie_pkg::S_MULDV)
  `PIE_ASSERT(a_no_take_in_clear, clk_i, rst_ni, clr_q |-> !in_acc)
  `PIE_ASSERT(a_txc_range, clk_i, rst_ni, txc_q != 2'd3)
endmodule
